@@ hw/rtl/averaged_ntc_temperature_linearizer_assert.svh @@
// Assertion macros shared by the linearizer checker.
`ifndef AVERAGED_NTC_TEMPERATURE_LINEARIZER_ASSERT_SVH
`define AVERAGED_NTC_TEMPERATURE_LINEARIZER_ASSERT_SVH
// Assert that an implication holds at every clock edge outside reset.
`define ANTL_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Assert that a condition implies a property in the next cycle.
`define ANTL_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

@@ hw/rtl/antl_pkg.sv @@
// Shared types, constants and table functions of the NTC linearizer.
package antl_pkg;

  localparam int LutPoints = 10;
  localparam int CntBits   = 12;
  localparam int TempBits  = 15;
  localparam int WinBits   = 5;
  localparam int ChanBits  = 3;
  localparam int SumBits   = 16;
  localparam int LutIdxBits = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_SEARCH,
    ST_MUL,
    ST_DIV2,
    ST_DONE
  } state_t;

  typedef logic [LutIdxBits-1:0] lut_idx_t;

  function automatic logic [CntBits-1:0] lut_count(input lut_idx_t i);
    logic [CntBits-1:0] v;
    case (i)
      4'd0: v = 12'd735;
      4'd1: v = 12'd1515;
      4'd2: v = 12'd1980;
      4'd3: v = 12'd2510;
      4'd4: v = 12'd2960;
      4'd5: v = 12'd3200;
      4'd6: v = 12'd3400;
      4'd7: v = 12'd3540;
      4'd8: v = 12'd3620;
      default: v = 12'd3650;
    endcase
    return v;
  endfunction

  function automatic logic [TempBits-1:0] lut_temp(input lut_idx_t i);
    logic [TempBits-1:0] v;
    case (i)
      4'd0: v = 15'd5248;
      4'd1: v = 15'd7168;
      4'd2: v = 15'd8448;
      4'd3: v = 15'd10752;
      4'd4: v = 15'd13312;
      4'd5: v = 15'd15616;
      4'd6: v = 15'd17920;
      4'd7: v = 15'd20480;
      4'd8: v = 15'd22016;
      default: v = 15'd23040;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/antl_ram.sv @@
// Generic single-port-write RAM with registered read.
module antl_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/antl_divider.sv @@
// Restoring divider, one quotient bit per cycle, shared by average and interpolation.
module antl_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [20:0] dividend,
  input  logic [11:0] divisor,
  output logic        busy,
  output logic [20:0] quotient
);

  logic [20:0] quo_r, quo_nxt;
  logic [12:0] rem_r, rem_nxt;
  logic [11:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [12:0] trial;
  logic [13:0] diff;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r[11:0], quo_r[20]};
    diff    = {1'b0, trial} - {2'b00, dvs_r};
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = 5'd21;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 5'd1;
      if (!diff[13]) begin
        rem_nxt = diff[12:0];
        quo_nxt = {quo_r[19:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[19:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

@@ hw/rtl/averaged_ntc_temperature_linearizer.sv @@
// Top level of the averaged NTC temperature linearizer.
// One sample beat in, one result beat out. Each item runs a per-channel moving
// average over a history RAM, a 21-step divide for the mean, a three- or four-step
// bisection of the 10-point table, one multiply and a second 21-step divide on the
// same bit-serial divider, which sets the pace; a new item is taken only once the
// last one has moved its result into the output register. in_stall is high from
// the input beat until that move; a result beat that waits there holds the next
// item at its last step. Pass-through items skip the mean divide, and counts that
// clamp at either end of the table skip the bisection and the second divide.
// The history RAM needs no clearing after reset.
module averaged_ntc_temperature_linearizer #(
  parameter int NUM_CHANNELS = 6,
  parameter int MAX_WINDOW   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_avg_window,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_channel,
  input  logic [11:0] in_raw_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_channel,
  output logic [11:0] out_averaged_count,
  output logic [14:0] out_temperature_q8
);

  localparam int IdxBits  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int ChBits   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int Depth    = NUM_CHANNELS * MAX_WINDOW;
  localparam int AddrBits = $clog2(Depth);

  antl_pkg::state_t state_r, state_nxt;

  logic [4:0]  window_r;
  logic [15:0] sum_r  [NUM_CHANNELS];
  logic [4:0]  fill_r [NUM_CHANNELS];
  logic [IdxBits-1:0] widx_r [NUM_CHANNELS];

  logic [2:0]  ch_r;
  logic [11:0] smp_r;
  logic [11:0] avg_r, avg_nxt;
  logic [14:0] temp_r, temp_nxt;
  logic [15:0] csum_r, csum_nxt;
  logic [4:0]  cfill_r, cfill_nxt;
  logic        bypass_r;
  antl_pkg::lut_idx_t lo_r, lo_nxt, hi_r, hi_nxt;
  logic [20:0] prod_r, prod_nxt;
  logic        ov_r, ov_nxt;
  logic        interp_r, interp_nxt;
  logic [2:0]  och_r, och_nxt;
  logic [11:0] oavg_r, oavg_nxt;
  logic [14:0] otemp_r, otemp_nxt;

  logic [ChBits-1:0] chi;
  logic [AddrBits-1:0] ram_addr;
  logic [11:0] ram_rdata;
  logic        ram_we;

  logic        div_start, div_busy;
  logic [20:0] div_dividend, div_quot;
  logic [11:0] div_divisor;

  logic        accept, upd;
  logic [4:0]  fill_new;
  logic [15:0] sum_new;
  logic [IdxBits:0] idx_inc;
  logic [IdxBits-1:0] idx_new;
  antl_pkg::lut_idx_t mid;
  logic [11:0] dcount;
  logic [14:0] dtemp;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != antl_pkg::ST_IDLE);
  assign chi = ch_r[ChBits-1:0];
  assign ram_addr = AddrBits'(chi * MAX_WINDOW + widx_r[chi]);

  antl_ram #(.WIDTH(12), .DEPTH(Depth)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (smp_r),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // The interpolation divide reuses ST_DIV; its operands come from the bracket.
  assign div_dividend = interp_r ? prod_r : {5'd0, csum_r};
  assign div_divisor  = interp_r ? dcount : {7'd0, cfill_r};

  antl_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  assign mid    = antl_pkg::lut_idx_t'((5'(lo_r) + 5'(hi_r)) >> 1);
  assign dcount = antl_pkg::lut_count(hi_r) - antl_pkg::lut_count(lo_r);
  assign dtemp  = antl_pkg::lut_temp(hi_r) - antl_pkg::lut_temp(lo_r);

  always_comb begin
    state_nxt    = state_r;
    avg_nxt      = avg_r;
    temp_nxt     = temp_r;
    csum_nxt     = csum_r;
    cfill_nxt    = cfill_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    prod_nxt     = prod_r;
    ov_nxt       = ov_r;
    interp_nxt   = interp_r;
    och_nxt      = och_r;
    oavg_nxt     = oavg_r;
    otemp_nxt    = otemp_r;
    ram_we       = 1'b0;
    upd          = 1'b0;
    div_start    = 1'b0;
    fill_new     = fill_r[chi];
    sum_new      = sum_r[chi];
    idx_inc      = {1'b0, widx_r[chi]} + 1'b1;
    idx_new      = (6'(idx_inc) >= 6'(window_r)) ? '0 : idx_inc[IdxBits-1:0];
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      antl_pkg::ST_IDLE: begin
        interp_nxt = 1'b0;
        if (accept) begin
          state_nxt = antl_pkg::ST_READ;
        end
      end
      antl_pkg::ST_READ: begin
        // RAM read of the slot being replaced lands next cycle.
        if (bypass_r) begin
          avg_nxt   = smp_r;
          state_nxt = antl_pkg::ST_SEARCH;
        end else begin
          state_nxt = antl_pkg::ST_UPDATE;
        end
      end
      antl_pkg::ST_UPDATE: begin
        ram_we = 1'b1;
        upd    = 1'b1;
        if (fill_r[chi] < window_r) begin
          fill_new = fill_r[chi] + 5'd1;
          sum_new  = sum_r[chi] + 16'(smp_r);
        end else begin
          sum_new  = sum_r[chi] - 16'(ram_rdata) + 16'(smp_r);
        end
        csum_nxt  = sum_new;
        cfill_nxt = fill_new;
        state_nxt = antl_pkg::ST_DIV;
      end
      antl_pkg::ST_DIV: begin
        div_start = 1'b1;
        state_nxt = antl_pkg::ST_DIV2;
      end
      antl_pkg::ST_DIV2: begin
        // Shared divider: first for the mean, then for interpolation.
        if (!div_busy) begin
          if (interp_r) begin
            temp_nxt  = antl_pkg::lut_temp(lo_r) + 15'(div_quot);
            state_nxt = antl_pkg::ST_DONE;
          end else begin
            avg_nxt   = (div_quot > 21'd4095) ? 12'hFFF : div_quot[11:0];
            state_nxt = antl_pkg::ST_SEARCH;
          end
        end
      end
      antl_pkg::ST_SEARCH: begin
        lo_nxt = '0;
        hi_nxt = antl_pkg::lut_idx_t'(antl_pkg::LutPoints - 1);
        if (avg_r <= antl_pkg::lut_count('0)) begin
          temp_nxt  = antl_pkg::lut_temp('0);
          state_nxt = antl_pkg::ST_DONE;
        end else if (avg_r >= antl_pkg::lut_count(hi_nxt)) begin
          temp_nxt  = antl_pkg::lut_temp(hi_nxt);
          state_nxt = antl_pkg::ST_DONE;
        end else begin
          state_nxt = antl_pkg::ST_MUL;
        end
      end
      antl_pkg::ST_MUL: begin
        // Bisect one step per cycle; multiply once the bracket is adjacent.
        if (4'(hi_r - lo_r) > 4'd1) begin
          if (avg_r >= antl_pkg::lut_count(mid)) begin
            lo_nxt = mid;
          end else begin
            hi_nxt = mid;
          end
        end else begin
          prod_nxt   = 21'((avg_r - antl_pkg::lut_count(lo_r)) * 12'(dtemp));
          interp_nxt = 1'b1;
          state_nxt  = antl_pkg::ST_DIV;
        end
      end
      antl_pkg::ST_DONE: begin
        // The output register frees up in the cycle its beat is taken.
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          och_nxt   = ch_r;
          oavg_nxt  = avg_r;
          otemp_nxt = temp_r;
          state_nxt = antl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = antl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= antl_pkg::ST_IDLE;
      window_r <= 5'd8;
      ov_r     <= 1'b0;
      interp_r <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        sum_r[c]  <= '0;
        fill_r[c] <= '0;
        widx_r[c] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      interp_r <= interp_nxt;
      ov_r     <= ov_nxt;
      if (cfg_we) begin
        window_r <= cfg_avg_window;
      end
      if (upd) begin
        sum_r[chi]  <= sum_new;
        fill_r[chi] <= fill_new;
        widx_r[chi] <= idx_new;
      end
    end
    if (accept) begin
      ch_r     <= in_channel;
      smp_r    <= in_raw_sample;
      bypass_r <= (window_r == '0) || (6'(window_r) > 6'(MAX_WINDOW))
                  || (5'(in_channel) >= 5'(NUM_CHANNELS));
    end
    avg_r   <= avg_nxt;
    temp_r  <= temp_nxt;
    csum_r  <= csum_nxt;
    cfill_r <= cfill_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    prod_r  <= prod_nxt;
    och_r   <= och_nxt;
    oavg_r  <= oavg_nxt;
    otemp_r <= otemp_nxt;
  end

  assign out_valid          = ov_r;
  assign out_channel        = och_r;
  assign out_averaged_count = oavg_r;
  assign out_temperature_q8 = otemp_r;

endmodule

@@ hw/rtl/antl_checker.sv @@
// Port-level checker for the linearizer, bound to the top level.
`include "averaged_ntc_temperature_linearizer_assert.svh"
module antl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_channel,
  input logic [14:0] out_temperature_q8
);
  `ANTL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_channel) && $stable(out_temperature_q8), "stalled beat changed")
  `ANTL_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall, "busy after beat")
  `ANTL_ASSERT_IMP(a_temp_low, clk, rst_n, out_valid, out_temperature_q8 >= 15'd5248, "temp low")
  `ANTL_ASSERT_IMP(a_temp_high, clk, rst_n, out_valid, out_temperature_q8 <= 15'd23040, "temp high")
endmodule

bind averaged_ntc_temperature_linearizer antl_checker u_antl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_channel        (out_channel),
  .out_temperature_q8 (out_temperature_q8)
);
